### src/dct8_pkg.sv
// Types, widths and the Q1.14 cosine table for the 8x8 forward DCT.
package dct8_pkg;

    localparam int BLOCK_DIM = 8;
    localparam int DIM_W     = 3;
    localparam int NSAMP     = BLOCK_DIM * BLOCK_DIM;
    localparam int IDX_W     = 6;

    localparam int SAMP_W    = 9;
    localparam int COEF_W    = 15;   // signed Q1.14 table entry
    localparam int ROW_W     = 26;   // row-pass word, 14 fraction bits
    localparam int PROD_W    = ROW_W + COEF_W;
    localparam int ACC_W     = PROD_W + DIM_W;
    localparam int RND_SHIFT = 26;   // 28 fraction bits down to quarters
    localparam int SCL_W     = ACC_W - RND_SHIFT;
    localparam int OUT_W     = 14;

    localparam int SEQ_W     = 1 + 3 * DIM_W;   // {phase, i, j, k}

    localparam logic signed [SCL_W-1:0] SCL_MAX = 18'sd8191;
    localparam logic signed [SCL_W-1:0] SCL_MIN = -18'sd8192;
    localparam logic signed [ACC_W-1:0] RND_HALF = 44'sd33554432;

    typedef logic signed [COEF_W-1:0] t_coef;

    // s(i) * cos(m*pi/16) rounded to Q1.14
    localparam t_coef K0 = 15'sd5793;
    localparam t_coef K1 = 15'sd8035;
    localparam t_coef K2 = 15'sd7568;
    localparam t_coef K3 = 15'sd6811;
    localparam t_coef K4 = 15'sd5793;
    localparam t_coef K5 = 15'sd4551;
    localparam t_coef K6 = 15'sd3135;
    localparam t_coef K7 = 15'sd1598;

    // C[i][j] at index i*8 + j
    localparam t_coef C_TAB [0:NSAMP-1] = '{
         K0,  K0,  K0,  K0,  K0,  K0,  K0,  K0,
         K1,  K3,  K5,  K7, -K7, -K5, -K3, -K1,
         K2,  K6, -K6, -K2, -K2, -K6,  K6,  K2,
         K3, -K7, -K1, -K5,  K5,  K1,  K7, -K3,
         K4, -K4, -K4,  K4,  K4, -K4, -K4,  K4,
         K5, -K1,  K7,  K3, -K3, -K7,  K1, -K5,
         K6, -K2,  K2, -K6, -K6,  K2, -K2,  K6,
         K7, -K5,  K3, -K1,  K1, -K3,  K5, -K7
    };

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    // control that travels down the MAC pipeline beside the data
    typedef struct packed {
        logic             vld;
        logic             phase;   // 0: row pass, 1: column pass
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] idx;
    } t_ctl;

endpackage

### src/dct_8x8_forward.sv
// Forward 8x8 DCT-II top level: sample store, shared MAC, row-pass store, output rounding.
//
//  port group       dir  width      transfer
//  start/i_sample   in   1 / 9      start high and busy low at the clock edge
//  o_valid/o_coef*  out  1/14/6/1   o_valid high for one cycle, always taken
//
// 64 samples are taken one per cycle while busy is low and start is high.
// After the 64th, busy rises and one shared 26x15 multiplier with a 44-bit
// accumulator runs 1024 products (512 row pass, 512 column pass), one per
// cycle, then the pipeline drains. Coefficients leave during the column pass,
// one per finished sum over k; busy falls with the last one. Reset clears the
// sequencer and the pipeline and output valid flags; stores hold garbage.
module dct_8x8_forward
    import dct8_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic signed [SAMP_W-1:0] i_sample,
    output logic                     busy,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_coefficient,
    output logic [IDX_W-1:0]         o_coef_index,
    output logic                     o_last
);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_count;
    logic [SEQ_W-1:0] r_seq;

    logic [SAMP_W-1:0] sample_mem [0:NSAMP-1];
    logic [ROW_W-1:0]  row_mem    [0:NSAMP-1];

    logic [SAMP_W-1:0] r_smp_rd;
    logic [ROW_W-1:0]  r_row_rd;
    t_coef             r_coef;
    t_ctl              n_ctl0, r_ctl1, r_ctl2;

    logic signed [ROW_W-1:0]  w_op;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_sum;

    logic                     r_fin_vld;
    logic [IDX_W-1:0]         r_fin_idx;
    logic signed [ACC_W-1:0]  r_fin_sum;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [SCL_W-1:0]  w_scaled;
    logic signed [OUT_W-1:0]  w_sat;

    logic             w_accept;
    logic             w_phase;
    logic [DIM_W-1:0] w_i, w_j, w_k;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_LOAD);
    assign {w_phase, w_i, w_j, w_k} = r_seq;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && r_count == IDX_W'(NSAMP - 1)) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (&r_seq) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_fin_vld && r_fin_idx == IDX_W'(NSAMP - 1)) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) r_count <= r_count + 1'b1;
            if (r_state == ST_RUN) r_seq <= r_seq + 1'b1;
            else r_seq <= '0;
        end
    end

    // sample store: written on transfer, read in the row pass at B[k][j]
    always_ff @(posedge i_clk) begin
        if (w_accept) sample_mem[r_count] <= i_sample;
        r_smp_rd <= sample_mem[{w_k, w_j}];
        r_row_rd <= row_mem[{w_i, w_k}];
    end

    always_comb begin
        n_ctl0.vld   = (r_state == ST_RUN);
        n_ctl0.phase = w_phase;
        n_ctl0.first = (w_k == '0);
        n_ctl0.lastk = (&w_k);
        n_ctl0.idx   = {w_i, w_j};
    end

    // stage 1: operand fetch and coefficient lookup
    always_ff @(posedge i_clk) begin
        r_coef <= w_phase ? C_TAB[{w_j, w_k}] : C_TAB[{w_i, w_k}];
        if (!i_rst_n) r_ctl1 <= '0;
        else r_ctl1 <= n_ctl0;
    end

    assign w_op   = r_ctl1.phase ? signed'(r_row_rd)
                                 : signed'({{(ROW_W - SAMP_W){r_smp_rd[SAMP_W-1]}}, r_smp_rd});
    assign w_prod = w_op * r_coef;

    // stage 2: product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) r_ctl2 <= '0;
        else r_ctl2 <= r_ctl1;
    end

    assign w_sum = (r_ctl2.first ? '0 : r_acc)
                 + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // stage 3: accumulate; row-pass results go back into the row store
    always_ff @(posedge i_clk) begin
        if (r_ctl2.vld) r_acc <= w_sum;
        if (r_ctl2.vld && r_ctl2.lastk && !r_ctl2.phase)
            row_mem[r_ctl2.idx] <= w_sum[ROW_W-1:0];
        r_fin_idx <= r_ctl2.idx;
        r_fin_sum <= w_sum;
        if (!i_rst_n) r_fin_vld <= 1'b0;
        else r_fin_vld <= r_ctl2.vld && r_ctl2.lastk && r_ctl2.phase;
    end

    // round to quarters (half up), then saturate
    assign w_rnd    = r_fin_sum + RND_HALF;
    assign w_scaled = w_rnd[ACC_W-1:RND_SHIFT];

    always_comb begin
        if (w_scaled > SCL_MAX) w_sat = SCL_MAX[OUT_W-1:0];
        else if (w_scaled < SCL_MIN) w_sat = SCL_MIN[OUT_W-1:0];
        else w_sat = w_scaled[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_coefficient <= w_sat;
        o_coef_index  <= r_fin_idx;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            o_valid <= r_fin_vld;
            o_last  <= r_fin_vld && (r_fin_idx == IDX_W'(NSAMP - 1));
        end
    end

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_coef_index == IDX_W'(NSAMP - 1))
        else $error("last strobe on wrong coefficient index");

    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("coefficient transfer while idle");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid && o_last)
        else $error("busy dropped before the last coefficient");

    a_no_mac_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> !n_ctl0.vld)
        else $error("MAC issued while loading samples");

endmodule
